// File: hw/rtl/bsr_pkg.sv
// bsr_pkg: shared constants, codes and helpers for the beacon scheduler.
// No dependencies; used by bsr_divider and beacon_scheduler_rotator.
`default_nettype none

package bsr_pkg;

    // Slot counts and time width
    localparam int PATH_SLOTS   = 8;
    localparam int STATUS_SLOTS = 8;
    localparam int TIME_BITS    = 48;

    localparam int PATH_CUR_W   = (PATH_SLOTS > 1) ? $clog2(PATH_SLOTS) : 1;
    localparam int STATUS_CUR_W = (STATUS_SLOTS > 1) ? $clog2(STATUS_SLOTS) : 1;
    localparam int MAX_SLOTS    = (PATH_SLOTS > STATUS_SLOTS) ? PATH_SLOTS : STATUS_SLOTS;
    localparam int STEP_W       = $clog2(MAX_SLOTS + 1);

    // Field widths
    localparam int CMD_W      = 2;
    localparam int NOW_W      = 48;
    localparam int SPEED_W    = 16;
    localparam int DELAY_W    = 16;
    localparam int MASK_W     = 8;
    localparam int SLOT_W     = 3;
    localparam int IVAL_W     = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Interval arithmetic, all in ms
    localparam logic [IVAL_W-1:0]    MIN_MS    = 26'd30000;
    localparam logic [IVAL_W-1:0]    MS_PER_S  = 26'd1000;
    localparam logic [IVAL_W-1:0]    SMART_NUM = 26'd57600000; // 3600000 ms*km/h, q4
    localparam logic [TIME_BITS-1:0] RETRY_MS  = TIME_BITS'(15000);
    localparam logic [SPEED_W-1:0]   SPEED_LO  = 16'd80;    // 5 km/h in q4
    localparam logic [SPEED_W-1:0]   SPEED_HI  = 16'd1760;  // 110 km/h in q4

    // Divider: one quotient bit per cycle
    localparam int DIV_STEPS = IVAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_SEND  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_REARM = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TX     = 3'd0,
        CFG_BEACON = 3'd1,
        CFG_AUTO   = 3'd2,
        CFG_SMART  = 3'd3,
        CFG_DELAY  = 3'd4,
        CFG_RETRY  = 3'd5,
        CFG_PMASK  = 3'd6,
        CFG_SMASK  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DECIDE,
        ST_WORK,
        ST_APPLY,
        ST_OUT
    } t_state;

    // Slots at index 8 and above never have an enable bit
    function automatic logic slot_on(logic [MASK_W-1:0] mask, logic [31:0] idx);
        logic on;
        on = 1'b0;
        if (idx < 32'(MASK_W)) begin
            on = mask[idx[2:0]];
        end
        return on;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/beacon_scheduler_rotator.sv
// beacon_scheduler_rotator: beacon timing, retry rule and path/status slot rotation.
// Depends on bsr_pkg and bsr_divider.
`default_nettype none

// Each input item (command, time in ms, GPS speed) yields exactly one result item.
// A tick fires a beacon on the 15 s retry rule or once now_ms reaches the
// next-beacon time; a manual send fires at once; both need tx and beacon enables, and a tick also the auto enable.
// A fired beacon advances the path and status cursors to the next enabled slot
// and rearms the next time with the fixed delay or the SmartBeaconing interval
// (57600000 / speed_q4, clamped to 30 s .. max(delay, 30 s)). The block takes one
// item at a time: an item that fires nothing passes through the calc, decide and
// output steps before the next accept; a beacon or rearm adds a work step and an
// apply step, and in the work step a beacon's slot scans go one slot per cycle
// alongside the serial divider when the speed-based quotient is needed.
// The result is held in an output register until taken; o_in_ready is high only
// while the sequencer is idle. Configuration writes land at once and are meant
// for idle periods.
module beacon_scheduler_rotator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [bsr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bsr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [bsr_pkg::CMD_W-1:0]         i_command,
    input  wire logic [bsr_pkg::NOW_W-1:0]         i_now_ms,
    input  wire logic [bsr_pkg::SPEED_W-1:0]       i_speed_q4,
    input  wire logic                              i_gps_valid,
    // result items
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_fired,
    output logic                                   o_was_retry,
    output logic                                   o_path_found,
    output logic [bsr_pkg::SLOT_W-1:0]             o_path_slot,
    output logic                                   o_status_found,
    output logic [bsr_pkg::SLOT_W-1:0]             o_status_slot,
    output logic [bsr_pkg::IVAL_W-1:0]             o_interval_ms
);

    // ---------------- registers ----------------
    bsr_pkg::t_state                        r_state, n_state;

    // configuration
    logic                                   r_tx_en, n_tx_en;
    logic                                   r_beacon_en, n_beacon_en;
    logic                                   r_auto_en, n_auto_en;
    logic                                   r_smart, n_smart;
    logic [bsr_pkg::DELAY_W-1:0]            r_delay, n_delay;
    logic                                   r_retry_en, n_retry_en;
    logic [bsr_pkg::MASK_W-1:0]             r_pmask, n_pmask;
    logic [bsr_pkg::MASK_W-1:0]             r_smask, n_smask;

    // scheduler state
    logic [bsr_pkg::PATH_CUR_W-1:0]         r_pcur, n_pcur;
    logic [bsr_pkg::STATUS_CUR_W-1:0]       r_scur, n_scur;
    logic [bsr_pkg::TIME_BITS-1:0]          r_next_time, n_next_time;
    logic [bsr_pkg::TIME_BITS-1:0]          r_last_sent, n_last_sent;
    logic                                   r_retry_pend, n_retry_pend;

    // latched item and work registers
    bsr_pkg::t_cmd                          r_cmd, n_cmd;
    logic [bsr_pkg::TIME_BITS-1:0]          r_now, n_now;
    logic [bsr_pkg::SPEED_W-1:0]            r_speed, n_speed;
    logic                                   r_gps, n_gps;
    logic [bsr_pkg::TIME_BITS-1:0]          r_elapsed, n_elapsed;
    logic                                   r_due, n_due;
    logic [bsr_pkg::IVAL_W-1:0]             r_fixed, n_fixed;
    logic [bsr_pkg::IVAL_W-1:0]             r_max, n_max;
    logic [bsr_pkg::IVAL_W-1:0]             r_ival, n_ival;
    logic                                   r_fire, n_fire;
    logic                                   r_is_retry, n_is_retry;
    logic [bsr_pkg::STEP_W-1:0]             r_step, n_step;
    logic                                   r_pf, n_pf;
    logic                                   r_sf, n_sf;

    // result register
    logic                                   r_fired, n_fired;
    logic                                   r_was_retry, n_was_retry;
    logic                                   r_path_found, n_path_found;
    logic [bsr_pkg::SLOT_W-1:0]             r_path_slot, n_path_slot;
    logic                                   r_status_found, n_status_found;
    logic [bsr_pkg::SLOT_W-1:0]             r_status_slot, n_status_slot;
    logic [bsr_pkg::IVAL_W-1:0]             r_interval, n_interval;

    // ---------------- shared divider ----------------
    logic                                   div_start;
    logic                                   div_busy;
    logic [bsr_pkg::IVAL_W-1:0]             div_quo;

    bsr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (r_speed),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // ---------------- helpers ----------------
    logic [bsr_pkg::PATH_CUR_W-1:0]         pcur_inc;
    logic [bsr_pkg::STATUS_CUR_W-1:0]       scur_inc;
    logic                                   p_go, s_go;
    logic                                   need_div;
    logic [bsr_pkg::IVAL_W-1:0]             dyn_ival;
    logic [bsr_pkg::IVAL_W-1:0]             sel_ival;

    assign pcur_inc = (r_pcur == bsr_pkg::PATH_CUR_W'(bsr_pkg::PATH_SLOTS - 1))
                    ? '0 : r_pcur + 1'b1;
    assign scur_inc = (r_scur == bsr_pkg::STATUS_CUR_W'(bsr_pkg::STATUS_SLOTS - 1))
                    ? '0 : r_scur + 1'b1;

    // scan keeps stepping until a slot hits or every slot has been tried
    assign p_go = r_fire && !r_pf && (r_step < bsr_pkg::STEP_W'(bsr_pkg::PATH_SLOTS));
    assign s_go = r_fire && !r_sf && (r_step < bsr_pkg::STEP_W'(bsr_pkg::STATUS_SLOTS));

    // quotient only matters between 5 and 110 km/h with a valid fix
    assign need_div = r_smart && r_gps && (r_speed >= bsr_pkg::SPEED_LO)
                    && (r_speed <= bsr_pkg::SPEED_HI);

    always_comb begin
        if (div_quo < bsr_pkg::MIN_MS) begin
            dyn_ival = bsr_pkg::MIN_MS;
        end else if (div_quo > r_max) begin
            dyn_ival = r_max;
        end else begin
            dyn_ival = div_quo;
        end

        if (!r_smart) begin
            sel_ival = r_fixed;
        end else if (!r_gps || (r_speed < bsr_pkg::SPEED_LO)) begin
            sel_ival = r_max;
        end else if (r_speed > bsr_pkg::SPEED_HI) begin
            sel_ival = bsr_pkg::MIN_MS;
        end else begin
            sel_ival = dyn_ival;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state        = r_state;
        n_tx_en        = r_tx_en;
        n_beacon_en    = r_beacon_en;
        n_auto_en      = r_auto_en;
        n_smart        = r_smart;
        n_delay        = r_delay;
        n_retry_en     = r_retry_en;
        n_pmask        = r_pmask;
        n_smask        = r_smask;
        n_pcur         = r_pcur;
        n_scur         = r_scur;
        n_next_time    = r_next_time;
        n_last_sent    = r_last_sent;
        n_retry_pend   = r_retry_pend;
        n_cmd          = r_cmd;
        n_now          = r_now;
        n_speed        = r_speed;
        n_gps          = r_gps;
        n_elapsed      = r_elapsed;
        n_due          = r_due;
        n_fixed        = r_fixed;
        n_max          = r_max;
        n_ival         = r_ival;
        n_fire         = r_fire;
        n_is_retry     = r_is_retry;
        n_step         = r_step;
        n_pf           = r_pf;
        n_sf           = r_sf;
        n_fired        = r_fired;
        n_was_retry    = r_was_retry;
        n_path_found   = r_path_found;
        n_path_slot    = r_path_slot;
        n_status_found = r_status_found;
        n_status_slot  = r_status_slot;
        n_interval     = r_interval;
        div_start      = 1'b0;
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;

        if (i_cfg_wr_en) begin
            unique case (bsr_pkg::t_cfg_idx'(i_cfg_index))
                bsr_pkg::CFG_TX:     n_tx_en     = i_cfg_data[0];
                bsr_pkg::CFG_BEACON: n_beacon_en = i_cfg_data[0];
                bsr_pkg::CFG_AUTO:   n_auto_en   = i_cfg_data[0];
                bsr_pkg::CFG_SMART:  n_smart     = i_cfg_data[0];
                bsr_pkg::CFG_DELAY:  n_delay     = i_cfg_data[bsr_pkg::DELAY_W-1:0];
                bsr_pkg::CFG_RETRY:  n_retry_en  = i_cfg_data[0];
                bsr_pkg::CFG_PMASK:  n_pmask     = i_cfg_data[bsr_pkg::MASK_W-1:0];
                bsr_pkg::CFG_SMASK:  n_smask     = i_cfg_data[bsr_pkg::MASK_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            bsr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd   = bsr_pkg::t_cmd'(i_command);
                    n_now   = bsr_pkg::TIME_BITS'(i_now_ms);
                    n_speed = i_speed_q4;
                    n_gps   = i_gps_valid;
                    n_state = bsr_pkg::ST_CALC;
                end
            end

            // elapsed time, due compare and fixed interval, each in its own register
            bsr_pkg::ST_CALC: begin
                n_elapsed = r_now - r_last_sent;
                n_due     = (r_now >= r_next_time);
                n_fixed   = bsr_pkg::IVAL_W'(r_delay) * bsr_pkg::MS_PER_S;
                n_state   = bsr_pkg::ST_DECIDE;
            end

            bsr_pkg::ST_DECIDE: begin
                n_max          = (r_fixed < bsr_pkg::MIN_MS) ? bsr_pkg::MIN_MS : r_fixed;
                n_fire         = 1'b0;
                n_is_retry     = 1'b0;
                n_fired        = 1'b0;
                n_was_retry    = 1'b0;
                n_path_found   = 1'b0;
                n_path_slot    = '0;
                n_status_found = 1'b0;
                n_status_slot  = '0;
                n_interval     = '0;
                n_step         = '0;
                n_pf           = 1'b0;
                n_sf           = 1'b0;
                n_state        = bsr_pkg::ST_OUT;

                unique case (r_cmd)
                    bsr_pkg::CMD_TICK: begin
                        if (r_auto_en && r_tx_en && r_beacon_en) begin
                            // retry rule wins over the schedule
                            if (r_retry_pend && r_retry_en
                                    && (r_elapsed >= bsr_pkg::RETRY_MS)) begin
                                n_fire     = 1'b1;
                                n_is_retry = 1'b1;
                            end else if (r_due) begin
                                n_fire = 1'b1;
                            end
                        end
                    end
                    bsr_pkg::CMD_SEND: begin
                        n_fire = r_tx_en && r_beacon_en;
                    end
                    bsr_pkg::CMD_CLEAR: begin
                        n_retry_pend = 1'b0;
                    end
                    bsr_pkg::CMD_REARM: ;
                    default: ;
                endcase

                if (n_fire || (r_cmd == bsr_pkg::CMD_REARM)) begin
                    div_start = need_div;
                    n_state   = bsr_pkg::ST_WORK;
                end
            end

            // slot scans step alongside the divider
            bsr_pkg::ST_WORK: begin
                if (p_go) begin
                    n_pcur = pcur_inc;
                    n_pf   = bsr_pkg::slot_on(r_pmask, 32'(pcur_inc));
                end
                if (s_go) begin
                    n_scur = scur_inc;
                    n_sf   = bsr_pkg::slot_on(r_smask, 32'(scur_inc));
                end
                if (p_go || s_go) begin
                    n_step = r_step + 1'b1;
                end
                if (!p_go && !s_go && !div_busy) begin
                    n_ival  = sel_ival;
                    n_state = bsr_pkg::ST_APPLY;
                end
            end

            bsr_pkg::ST_APPLY: begin
                n_next_time = r_now + bsr_pkg::TIME_BITS'(r_ival);
                n_interval  = r_ival;
                if (r_fire) begin
                    n_last_sent    = r_now;
                    if (r_retry_en) begin
                        n_retry_pend = 1'b1;
                    end
                    n_fired        = 1'b1;
                    n_was_retry    = r_is_retry;
                    n_path_found   = r_pf;
                    n_path_slot    = r_pf ? bsr_pkg::SLOT_W'(r_pcur) : '0;
                    n_status_found = r_sf;
                    n_status_slot  = r_sf ? bsr_pkg::SLOT_W'(r_scur) : '0;
                end
                n_state = bsr_pkg::ST_OUT;
            end

            bsr_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = bsr_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = bsr_pkg::ST_IDLE;
            end
        endcase
    end

    // control and scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bsr_pkg::ST_IDLE;
            r_tx_en      <= 1'b0;
            r_beacon_en  <= 1'b0;
            r_auto_en    <= 1'b0;
            r_smart      <= 1'b0;
            r_delay      <= bsr_pkg::DELAY_W'(600);
            r_retry_en   <= 1'b0;
            r_pmask      <= '0;
            r_smask      <= '0;
            r_pcur       <= '0;
            r_scur       <= '0;
            r_next_time  <= '0;
            r_last_sent  <= '0;
            r_retry_pend <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tx_en      <= n_tx_en;
            r_beacon_en  <= n_beacon_en;
            r_auto_en    <= n_auto_en;
            r_smart      <= n_smart;
            r_delay      <= n_delay;
            r_retry_en   <= n_retry_en;
            r_pmask      <= n_pmask;
            r_smask      <= n_smask;
            r_pcur       <= n_pcur;
            r_scur       <= n_scur;
            r_next_time  <= n_next_time;
            r_last_sent  <= n_last_sent;
            r_retry_pend <= n_retry_pend;
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        r_cmd          <= n_cmd;
        r_now          <= n_now;
        r_speed        <= n_speed;
        r_gps          <= n_gps;
        r_elapsed      <= n_elapsed;
        r_due          <= n_due;
        r_fixed        <= n_fixed;
        r_max          <= n_max;
        r_ival         <= n_ival;
        r_fire         <= n_fire;
        r_is_retry     <= n_is_retry;
        r_step         <= n_step;
        r_pf           <= n_pf;
        r_sf           <= n_sf;
        r_fired        <= n_fired;
        r_was_retry    <= n_was_retry;
        r_path_found   <= n_path_found;
        r_path_slot    <= n_path_slot;
        r_status_found <= n_status_found;
        r_status_slot  <= n_status_slot;
        r_interval     <= n_interval;
    end

    assign o_fired        = r_fired;
    assign o_was_retry    = r_was_retry;
    assign o_path_found   = r_path_found;
    assign o_path_slot    = r_path_slot;
    assign o_status_found = r_status_found;
    assign o_status_slot  = r_status_slot;
    assign o_interval_ms  = r_interval;

    // ---------------- assertions ----------------
    a_fire_needs_enables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fired) |-> (r_tx_en && r_beacon_en))
        else $error("beacon fired without tx and beacon enables");

    a_retry_implies_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_was_retry) |-> o_fired)
        else $error("retry flag set on a result that did not fire");

    a_slot_zero_when_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_path_found) |-> (o_path_slot == '0))
        else $error("path slot nonzero with no enabled path");

    a_smart_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fired && r_smart) |-> (o_interval_ms >= bsr_pkg::MIN_MS))
        else $error("smart interval below the 30 s floor");

    a_div_idle_at_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !div_busy)
        else $error("divider still busy while taking a new item");

endmodule

`default_nettype wire

// File: hw/rtl/bsr_divider.sv
// bsr_divider: restoring divider, SMART_NUM / divisor, one quotient bit per cycle.
// Depends on bsr_pkg.
`default_nettype none

module bsr_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [bsr_pkg::SPEED_W-1:0]   i_divisor,
    output logic                               o_busy,
    output logic [bsr_pkg::IVAL_W-1:0]         o_quotient
);

    logic                           r_busy;
    logic [bsr_pkg::DIV_CNT_W-1:0]  r_count;
    logic [bsr_pkg::SPEED_W-1:0]    r_rem;
    logic [bsr_pkg::SPEED_W-1:0]    r_div;
    logic [bsr_pkg::IVAL_W-1:0]     r_quo;

    logic [bsr_pkg::DIV_CNT_W-1:0]  bit_idx;
    logic [bsr_pkg::SPEED_W:0]      trial;
    logic                           ge;
    logic [bsr_pkg::SPEED_W-1:0]    rem_next;

    // MSB of the dividend first
    assign bit_idx  = bsr_pkg::DIV_CNT_W'(bsr_pkg::DIV_STEPS - 1) - r_count;
    assign trial    = {r_rem, bsr_pkg::SMART_NUM[bit_idx]};
    assign ge       = (trial >= {1'b0, r_div});
    assign rem_next = ge ? bsr_pkg::SPEED_W'(trial - {1'b0, r_div})
                         : trial[bsr_pkg::SPEED_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_count <= '0;
        end else if (r_busy) begin
            if (r_count == bsr_pkg::DIV_CNT_W'(bsr_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[bsr_pkg::IVAL_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire
